FILE: sv/scgr_pkg.sv
// ----------------------------------------------------------------------------
// scgr_pkg
// Shared types, codes and the 5x7 font table for the glyph column renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package scgr_pkg;

    // font geometry: five font columns and one blank spacer column
    localparam int GLYPH_WIDTH = 5;

    // scale register codes
    localparam logic [1:0] SCALE_X2 = 2'd1;
    localparam logic [1:0] SCALE_X4 = 2'd2;

    // character codes with a glyph of their own
    localparam logic [7:0] CODE_MINUS  = 8'h2D;
    localparam logic [7:0] CODE_PLUS   = 8'h2B;
    localparam logic [7:0] CODE_DOT    = 8'h2E;
    localparam logic [7:0] CODE_DEGREE = 8'hA1;

    // glyph indexes of the symbols
    localparam logic [5:0] SYM_MINUS  = 6'd36;
    localparam logic [5:0] SYM_PLUS   = 6'd37;
    localparam logic [5:0] SYM_DOT    = 6'd38;
    localparam logic [5:0] SYM_DEGREE = 6'd39;
    localparam logic [5:0] SYM_BLANK  = 6'd40;

    // repeat count minus one for each scale
    typedef enum logic [1:0] {
        REP_X1 = 2'd0,
        REP_X2 = 2'd1,
        REP_X4 = 2'd3
    } t_rep;

    // one glyph, element 0 is the leftmost column, bit 0 the top pixel
    typedef logic [0:GLYPH_WIDTH-1][6:0] t_glyph;

    // classified character waiting for the column engine
    typedef struct packed {
        logic [5:0] glyph;
        t_rep       rep;
        logic       start;
        logic [6:0] start_col;
        logic [2:0] start_page;
        logic       final_char;
    } t_entry;

    // character code to glyph index, letters in either case
    function automatic logic [5:0] glyph_index(input logic [7:0] c);
        logic [5:0] g;
        g = SYM_BLANK;
        if (c >= 8'h41 && c <= 8'h5A) begin
            g = 6'(c - 8'h41) + 6'd10;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            g = 6'(c - 8'h61) + 6'd10;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            g = 6'(c - 8'h30);
        end else if (c == CODE_MINUS) begin
            g = SYM_MINUS;
        end else if (c == CODE_PLUS) begin
            g = SYM_PLUS;
        end else if (c == CODE_DOT) begin
            g = SYM_DOT;
        end else if (c == CODE_DEGREE) begin
            g = SYM_DEGREE;
        end
        return g;
    endfunction

    // font rom: digits, letters, then symbols
    function automatic t_glyph font_glyph(input logic [5:0] g);
        t_glyph v;
        case (g)
            6'd0:  v = {7'h3E, 7'h49, 7'h45, 7'h43, 7'h3E};
            6'd1:  v = {7'h00, 7'h04, 7'h02, 7'h7F, 7'h00};
            6'd2:  v = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            6'd3:  v = {7'h22, 7'h41, 7'h49, 7'h49, 7'h36};
            6'd4:  v = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            6'd5:  v = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            6'd6:  v = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h32};
            6'd7:  v = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            6'd8:  v = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd9:  v = {7'h26, 7'h49, 7'h49, 7'h49, 7'h3E};
            6'd10: v = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            6'd11: v = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd12: v = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            6'd13: v = {7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E};
            6'd14: v = {7'h7F, 7'h49, 7'h49, 7'h41, 7'h41};
            6'd15: v = {7'h7F, 7'h09, 7'h09, 7'h01, 7'h01};
            6'd16: v = {7'h3E, 7'h41, 7'h59, 7'h49, 7'h3A};
            6'd17: v = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            6'd18: v = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            6'd19: v = {7'h20, 7'h41, 7'h3F, 7'h01, 7'h00};
            6'd20: v = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
            6'd21: v = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            6'd22: v = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
            6'd23: v = {7'h7F, 7'h08, 7'h10, 7'h20, 7'h7F};
            6'd24: v = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            6'd25: v = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            6'd26: v = {7'h3E, 7'h41, 7'h51, 7'h61, 7'h3E};
            6'd27: v = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h76};
            6'd28: v = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            6'd29: v = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            6'd30: v = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            6'd31: v = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            6'd32: v = {7'h7F, 7'h20, 7'h10, 7'h20, 7'h7F};
            6'd33: v = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            6'd34: v = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
            6'd35: v = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            6'd36: v = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            6'd37: v = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            6'd38: v = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
            6'd39: v = {7'h00, 7'h06, 7'h09, 7'h06, 7'h00};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/scgr_front.sv
// ----------------------------------------------------------------------------
// scgr_front
// Accepts character requests, maps each code to a glyph index and a repeat
// count, and holds them in a two-entry queue for the column engine.
// ----------------------------------------------------------------------------
`default_nettype none

module scgr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_scale_mode,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_start_string,
    input  wire logic [6:0]       i_start_column,
    input  wire logic [2:0]       i_start_page,
    input  wire logic             i_final_char,
    output logic                  o_head_valid,
    input  wire logic             i_head_ready,
    output scgr_pkg::t_entry      o_head
);
    import scgr_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_entry     w_entry;
    logic       w_push;
    logic       w_pop;

    // classify the incoming request
    always_comb begin
        w_entry.glyph      = glyph_index(i_char_code);
        w_entry.start      = i_start_string;
        w_entry.start_col  = i_start_column;
        w_entry.start_page = i_start_page;
        w_entry.final_char = i_final_char;
        case (i_scale_mode)
            SCALE_X2: w_entry.rep = REP_X2;
            SCALE_X4: w_entry.rep = REP_X4;
            default:  w_entry.rep = REP_X1;
        endcase
    end

    // queue handshakes
    assign o_ready      = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_head_valid && i_head_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // fill level stays within the two entries
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue fill level out of range");

    // pointers differ whenever the queue holds exactly one entry
    a_ptr_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

FILE: sv/scgr_back.sv
// ----------------------------------------------------------------------------
// scgr_back
// Column engine: walks the font columns of the head entry, repeats each one
// for the scale, spreads the pixel bits over the pages and places the result
// at the running column counter.
// ----------------------------------------------------------------------------
`default_nettype none

module scgr_back #(
    parameter int DISPLAY_COLUMNS = 132
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    output logic                  o_head_ready,
    input  wire scgr_pkg::t_entry i_head,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_column_address,
    output logic [2:0]            o_top_page,
    output logic [7:0]            o_page_byte_0,
    output logic [7:0]            o_page_byte_1,
    output logic [7:0]            o_page_byte_2,
    output logic [7:0]            o_page_byte_3,
    output logic                  o_last_column,
    output logic                  o_string_done
);
    import scgr_pkg::*;

    localparam int CW = $clog2(DISPLAY_COLUMNS + 1);
    localparam int SW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] COL_LIMIT = CW'(DISPLAY_COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(DISPLAY_COLUMNS - 1);
    localparam logic [2:0]    GCOL_GAP  = 3'(GLYPH_WIDTH);

    logic [CW-1:0] r_col;
    logic [2:0]    r_page;
    logic [2:0]    r_gcol;
    logic [1:0]    r_rep;
    logic          r_out_valid;
    logic [7:0]    r_out_col;
    logic [2:0]    r_out_page;
    logic [7:0]    r_out_b0;
    logic [7:0]    r_out_b1;
    logic [7:0]    r_out_b2;
    logic [7:0]    r_out_b3;
    logic          r_out_last;
    logic          r_out_done;

    logic [SW-1:0] w_start_sum;
    logic [CW-1:0] w_load_col;
    logic [CW-1:0] w_cur_col;
    logic [2:0]    w_cur_page;
    logic          w_first;
    logic          w_drop;
    logic          w_out_free;
    logic          w_item_end;
    logic          w_last;
    logic          w_emit;
    logic          w_pop;
    t_glyph        w_glyph;
    logic [6:0]    w_bits;
    logic [7:0]    w_p0;
    logic [7:0]    w_p1;
    logic [7:0]    w_p2;
    logic [7:0]    w_p3;

    // position of this column, reloaded on the first column of a new string
    always_comb begin
        w_start_sum = SW'(i_head.start_col) + SW'(2);
        w_load_col  = (w_start_sum > SW'(DISPLAY_COLUMNS)) ? COL_LIMIT : CW'(w_start_sum);
        w_first     = (r_gcol == 3'd0) && (r_rep == 2'd0);
        w_cur_col   = (w_first && i_head.start) ? w_load_col : r_col;
        w_cur_page  = (w_first && i_head.start) ? i_head.start_page : r_page;
    end

    // step control
    always_comb begin
        w_drop       = (w_cur_col >= COL_LIMIT);
        w_out_free   = !r_out_valid || i_ready;
        w_item_end   = (r_gcol == GCOL_GAP) && (r_rep == i_head.rep);
        w_last       = w_item_end || (w_cur_col == COL_LAST);
        w_emit       = i_head_valid && !w_drop && w_out_free;
        w_pop        = i_head_valid && (w_drop || (w_out_free && w_last));
        o_head_ready = w_pop;
    end

    // font column and page spreading
    always_comb begin
        w_glyph = font_glyph(i_head.glyph);
        w_bits  = '0;
        if (r_gcol < GCOL_GAP) begin
            w_bits = w_glyph[r_gcol];
        end
        w_p0 = '0;
        w_p1 = '0;
        w_p2 = '0;
        w_p3 = '0;
        case (i_head.rep)
            REP_X2: begin
                w_p0 = {{2{w_bits[3]}}, {2{w_bits[2]}}, {2{w_bits[1]}}, {2{w_bits[0]}}};
                w_p1 = {2'b00, {2{w_bits[6]}}, {2{w_bits[5]}}, {2{w_bits[4]}}};
            end
            REP_X4: begin
                w_p0 = {{4{w_bits[1]}}, {4{w_bits[0]}}};
                w_p1 = {{4{w_bits[3]}}, {4{w_bits[2]}}};
                w_p2 = {{4{w_bits[5]}}, {4{w_bits[4]}}};
                w_p3 = {4'b0000, {4{w_bits[6]}}};
            end
            default: begin
                w_p0 = {1'b0, w_bits};
            end
        endcase
    end

    // column walk, position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= CW'(2);
            r_page      <= 3'd0;
            r_gcol      <= 3'd0;
            r_rep       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_gcol <= 3'd0;
                r_rep  <= 2'd0;
            end else if (w_emit) begin
                if (r_rep == i_head.rep) begin
                    r_rep  <= 2'd0;
                    r_gcol <= r_gcol + 3'd1;
                end else begin
                    r_rep <= r_rep + 2'd1;
                end
            end
            if (w_emit) begin
                r_col <= w_cur_col + CW'(1);
            end else if (w_pop) begin
                r_col <= w_cur_col;
            end
            if (w_emit || w_pop) begin
                r_page <= w_cur_page;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_col  <= 8'(w_cur_col);
            r_out_page <= w_cur_page;
            r_out_b0   <= w_p0;
            r_out_b1   <= w_p1;
            r_out_b2   <= w_p2;
            r_out_b3   <= w_p3;
            r_out_last <= w_last;
            r_out_done <= w_last && i_head.final_char;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_column_address = r_out_col;
    assign o_top_page       = r_out_page;
    assign o_page_byte_0    = r_out_b0;
    assign o_page_byte_1    = r_out_b1;
    assign o_page_byte_2    = r_out_b2;
    assign o_page_byte_3    = r_out_b3;
    assign o_last_column    = r_out_last;
    assign o_string_done    = r_out_done;

    // the column counter saturates at the display edge
    a_col_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LIMIT)
        else $error("column counter past display edge");

    // no column is emitted beyond the display
    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (9'(r_out_col) < 9'(DISPLAY_COLUMNS)))
        else $error("emitted column outside display");

    // string end only ever comes with the last column of a character
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("string done without last column");

    // font column index never runs past the spacer column
    a_gcol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcol <= GCOL_GAP)
        else $error("font column index out of range");

endmodule

`default_nettype wire

FILE: sv/scaled_glyph_column_renderer.sv
// ----------------------------------------------------------------------------
// scaled_glyph_column_renderer
// 5x7 character generator producing page-organized column bytes at 1x, 2x
// or 4x size for a monochrome display controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one character request: the code,
//   an optional string start with column and page, and a final-character
//   flag. Output channel (o_valid/i_ready) carries one display column per
//   transfer: column address, top page and four page bytes.
//   Each character gives 6 columns at normal size, 12 at double size and 24
//   at quadruple size, one column per cycle from the column engine while the
//   receiver takes them; columns at or past the display edge are skipped, and
//   a character with no column left on the display is dropped without output.
//   An accepted request is first written into the queue; its columns are
//   then registered in the output register. A two-entry queue sits between
//   the request side and the column engine, so requests keep arriving while
//   columns are drained. When the receiver stalls, the output register holds
//   its column and the engine waits; the queue then fills and o_ready drops.
//   Reset sets the column counter to 2, the page to 0 and the scale to
//   normal. scale_mode sits at APB byte address 0; the user must write it
//   only while the block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_column_renderer #(
    parameter int DISPLAY_COLUMNS = 132
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // character requests
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_start_string,
    input  wire logic [6:0]  i_start_column,
    input  wire logic [2:0]  i_start_page,
    input  wire logic        i_final_char,
    // display columns
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_column_address,
    output logic [2:0]       o_top_page,
    output logic [7:0]       o_page_byte_0,
    output logic [7:0]       o_page_byte_1,
    output logic [7:0]       o_page_byte_2,
    output logic [7:0]       o_page_byte_3,
    output logic             o_last_column,
    output logic             o_string_done
);
    import scgr_pkg::*;

    // word index of the scale register
    localparam logic REG_SCALE_MODE = 1'b0;

    logic [1:0] r_scale_mode;
    logic       w_cfg_wr;
    logic       w_head_valid;
    logic       w_head_ready;
    t_entry     w_head;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCALE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode <= 2'd0;
        end else if (w_cfg_wr) begin
            r_scale_mode <= pwdata[1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SCALE_MODE) begin
            prdata = 32'(r_scale_mode);
        end
    end

    // request classification and queue
    scgr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scale_mode   (r_scale_mode),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_start_string (i_start_string),
        .i_start_column (i_start_column),
        .i_start_page   (i_start_page),
        .i_final_char   (i_final_char),
        .o_head_valid   (w_head_valid),
        .i_head_ready   (w_head_ready),
        .o_head         (w_head)
    );

    // column engine
    scgr_back #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (w_head_valid),
        .o_head_ready     (w_head_ready),
        .i_head           (w_head),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_column_address (o_column_address),
        .o_top_page       (o_top_page),
        .o_page_byte_0    (o_page_byte_0),
        .o_page_byte_1    (o_page_byte_1),
        .o_page_byte_2    (o_page_byte_2),
        .o_page_byte_3    (o_page_byte_3),
        .o_last_column    (o_last_column),
        .o_string_done    (o_string_done)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled glyph column renderer. A directed table
// and random character strings go out under a sequence of scale settings,
// bursty requests and a stalling receiver. Each display column is compared
// to a behavioral renderer kept in step with accepted requests, or typed rows.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scgr_pkg::*;

    // scale codes the package does not name
    localparam logic [1:0] SCALE_X1   = 2'd0;
    localparam logic [1:0] SCALE_RSVD = 2'd3;

    localparam logic [2:0] REG_SCALE_ADDR = 3'd0;
    localparam int         DISPLAY_COLS   = 132;
    localparam int         SETTLE_CYCLES  = 20;
    localparam int         RANDOM_PHASES  = 8;
    localparam int         PHASE_CHARS    = 48;

    // font: digits, letters, minus, plus, dot, degree, blank
    localparam logic [0:40][0:4][6:0] GLYPH_BITS = {
        {7'h3E, 7'h49, 7'h45, 7'h43, 7'h3E}, {7'h00, 7'h04, 7'h02, 7'h7F, 7'h00},
        {7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, {7'h22, 7'h41, 7'h49, 7'h49, 7'h36},
        {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, {7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        {7'h3E, 7'h49, 7'h49, 7'h49, 7'h32}, {7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        {7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, {7'h26, 7'h49, 7'h49, 7'h49, 7'h3E},
        {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
        {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, {7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E},
        {7'h7F, 7'h49, 7'h49, 7'h41, 7'h41}, {7'h7F, 7'h09, 7'h09, 7'h01, 7'h01},
        {7'h3E, 7'h41, 7'h59, 7'h49, 7'h3A}, {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
        {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, {7'h20, 7'h41, 7'h3F, 7'h01, 7'h00},
        {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
        {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F}, {7'h7F, 7'h08, 7'h10, 7'h20, 7'h7F},
        {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
        {7'h3E, 7'h41, 7'h51, 7'h61, 7'h3E}, {7'h7F, 7'h09, 7'h09, 7'h09, 7'h76},
        {7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
        {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
        {7'h7F, 7'h20, 7'h10, 7'h20, 7'h7F}, {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        {7'h03, 7'h04, 7'h78, 7'h04, 7'h03}, {7'h61, 7'h51, 7'h49, 7'h45, 7'h43},
        {7'h08, 7'h08, 7'h08, 7'h08, 7'h08}, {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08},
        {7'h00, 7'h60, 7'h60, 7'h00, 7'h00}, {7'h00, 7'h06, 7'h09, 7'h06, 7'h00},
        {7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };
    localparam int GLYPH_MINUS  = 36;
    localparam int GLYPH_PLUS   = 37;
    localparam int GLYPH_DOT    = 38;
    localparam int GLYPH_DEGREE = 39;
    localparam int GLYPH_SPACE  = 40;

    typedef struct packed {
        logic [7:0] code;
        logic       start;
        logic [6:0] col;
        logic [2:0] page;
        logic       fin;
    } t_char_req;

    typedef struct packed {
        logic [7:0] col;
        logic [2:0] page;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       last;
        logic       done;
    } t_col_result;

    // tn < 0: columns come from the renderer model, else typed in
    typedef struct {
        logic [1:0] scale;
        t_char_req  rq;
        int         tn;
        int         tcol;
        int         tpg;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_ready;
    logic [7:0]  i_char_code;
    logic        i_start_string;
    logic [6:0]  i_start_column;
    logic [2:0]  i_start_page;
    logic        i_final_char;
    logic        o_valid, i_ready;
    logic [7:0]  o_column_address;
    logic [2:0]  o_top_page;
    logic [7:0]  o_page_byte_0, o_page_byte_1, o_page_byte_2, o_page_byte_3;
    logic        o_last_column, o_string_done;

    // renderer model state
    int          col_ctr  = 2;
    logic [2:0]  page_reg = 3'd0;
    logic [1:0]  scale_reg = SCALE_X1;

    t_col_result expected_columns[$];
    t_dir_row    directed_rows[$];

    int          err_count       = 0;
    int          chars_sent      = 0;
    int          chars_dropped   = 0;
    int          columns_checked = 0;
    int          scale_writes    = 0;
    int          burst_left      = 0;
    logic [3:0]  scales_seen     = 4'b0001;

    scaled_glyph_column_renderer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_code      (i_char_code),
        .i_start_string   (i_start_string),
        .i_start_column   (i_start_column),
        .i_start_page     (i_start_page),
        .i_final_char     (i_final_char),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_column_address (o_column_address),
        .o_top_page       (o_top_page),
        .o_page_byte_0    (o_page_byte_0),
        .o_page_byte_1    (o_page_byte_1),
        .o_page_byte_2    (o_page_byte_2),
        .o_page_byte_3    (o_page_byte_3),
        .o_last_column    (o_last_column),
        .o_string_done    (o_string_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic int glyph_of(input logic [7:0] code);
        if (code >= "A" && code <= "Z") return int'(code) - int'("A") + 10;
        if (code >= "a" && code <= "z") return int'(code) - int'("a") + 10;
        if (code >= "0" && code <= "9") return int'(code) - int'("0");
        if (code == CODE_MINUS)  return GLYPH_MINUS;
        if (code == CODE_PLUS)   return GLYPH_PLUS;
        if (code == CODE_DOT)    return GLYPH_DOT;
        if (code == CODE_DEGREE) return GLYPH_DEGREE;
        return GLYPH_SPACE;
    endfunction

    // repeat each of the low nbits bits rep times
    function automatic logic [7:0] stretch(input logic [3:0] v, input int nbits,
                                           input int rep);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < nbits; i++)
            if (v[i])
                for (int k = 0; k < rep; k++) r[i*rep+k] = 1'b1;
        return r;
    endfunction

    // advance the model by one character, queue its columns when keep is set
    task automatic render_char(input t_char_req rq, input bit keep, output int n_out);
        int               rep;
        int               g;
        logic [6:0]       bits;
        logic [3:0][7:0]  pb;
        t_col_result      res;
        t_col_result      cols[$];
        if (rq.start) begin
            col_ctr  = int'(rq.col) + 2;
            page_reg = rq.page;
            if (col_ctr > DISPLAY_COLS) col_ctr = DISPLAY_COLS;
        end
        rep = (scale_reg == SCALE_X2) ? 2 : (scale_reg == SCALE_X4) ? 4 : 1;
        g = glyph_of(rq.code);
        for (int c = 0; c <= GLYPH_WIDTH; c++) begin
            bits = (c < GLYPH_WIDTH) ? GLYPH_BITS[g][c] : 7'h00;
            pb = '0;
            if (rep == 1) begin
                pb[0] = {1'b0, bits};
            end else if (rep == 2) begin
                pb[0] = stretch(bits[3:0], 4, 2);
                pb[1] = stretch({1'b0, bits[6:4]}, 4, 2);
            end else begin
                pb[0] = stretch({2'b0, bits[1:0]}, 2, 4);
                pb[1] = stretch({2'b0, bits[3:2]}, 2, 4);
                pb[2] = stretch({2'b0, bits[5:4]}, 2, 4);
                pb[3] = stretch({3'b0, bits[6]}, 2, 4);
            end
            for (int r = 0; r < rep; r++) begin
                if (col_ctr < DISPLAY_COLS) begin
                    res = {8'(col_ctr), page_reg, pb[0], pb[1], pb[2], pb[3], 2'b00};
                    cols.push_back(res);
                    col_ctr++;
                end
            end
        end
        n_out = cols.size();
        if (n_out > 0) begin
            cols[n_out-1].last = 1'b1;
            cols[n_out-1].done = rq.fin;
        end
        if (keep)
            foreach (cols[i]) expected_columns.push_back(cols[i]);
    endtask

    // ---------------------------------------------------------------- checking

    function automatic string fmt_col(input t_col_result r);
        return $sformatf("col %0d page %0d bytes %h %h %h %h last %b done %b",
                         r.col, r.page, r.b0, r.b1, r.b2, r.b3, r.last, r.done);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : column_check
        t_col_result seen;
        t_col_result want;
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_column_address, o_top_page, o_page_byte_0, o_page_byte_1,
                    o_page_byte_2, o_page_byte_3, o_last_column, o_string_done};
            if (expected_columns.size() == 0) begin
                flag_error({"unexpected column: ", fmt_col(seen)});
            end else begin
                want = expected_columns.pop_front();
                columns_checked++;
                if (seen !== want)
                    flag_error({"column mismatch: expected ", fmt_col(want),
                                " / got ", fmt_col(seen)});
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // stall pattern: runs of always ready, coin flips, heavy stall, fixed mask
    initial begin : rx_pacing
        int         mode;
        int         span;
        logic [7:0] mask;
        i_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            mask = 8'($urandom) | 8'h01;
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= mask[k % 8];
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // present one request, hold it until taken, then maybe open a gap
    task automatic send_char(input t_char_req rq, input int tn, input int tcol,
                             input int tpg);
        int          n;
        t_col_result res;
        i_valid        <= 1'b1;
        i_char_code    <= rq.code;
        i_start_string <= rq.start;
        i_start_column <= rq.col;
        i_start_page   <= rq.page;
        i_final_char   <= rq.fin;
        do @(posedge i_clk); while (!o_ready);
        render_char(rq, tn < 0, n);
        if (tn >= 0) begin
            n = tn;
            for (int k = 0; k < tn; k++) begin
                res = {8'(tcol + k), 3'(tpg), 32'h0, k == tn - 1, rq.fin && k == tn - 1};
                expected_columns.push_back(res);
            end
        end
        chars_sent++;
        if (n == 0) chars_dropped++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // drain, write the scale register, read it back
    task automatic set_scale(input logic [1:0] v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SCALE_ADDR;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scale_reg = v;
        scales_seen[v] = 1'b1;
        scale_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(v))
            flag_error($sformatf("scale readback: expected %0d got %h", v, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_dir_row dir_row(input logic [1:0] sc, input logic [7:0] code,
                                         input bit st, input int col, input int pg,
                                         input bit fin, input int tn, input int tcol,
                                         input int tpg);
        t_dir_row r;
        r.scale = sc;
        r.rq    = {code, st, 7'(col), 3'(pg), fin};
        r.tn    = tn;
        r.tcol  = tcol;
        r.tpg   = tpg;
        return r;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(int'("A"), int'("Z")));
            3, 4:    return 8'($urandom_range(int'("a"), int'("z")));
            5:       return 8'($urandom_range(int'("0"), int'("9")));
            6: begin
                case ($urandom_range(0, 3))
                    0:       return CODE_MINUS;
                    1:       return CODE_PLUS;
                    2:       return CODE_DOT;
                    default: return CODE_DEGREE;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- main

    initial begin : stimulus
        t_char_req  rq;
        logic [1:0] phase_scale [0:RANDOM_PHASES-1];
        int         phase_sent;
        int         len;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_char_code    = '0;
        i_start_string = 1'b0;
        i_start_column = '0;
        i_start_page   = '0;
        i_final_char   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset position, glyph classes, edges, every scale
        // blank right after reset lands at column two on page zero
        directed_rows.push_back(dir_row(SCALE_X1, 8'h00, 0, 0, 0, 0, 6, 2, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "A", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "z", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "0", 1, 0, 1, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "9", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, CODE_MINUS, 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, CODE_PLUS, 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, CODE_DOT, 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, CODE_DEGREE, 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "Z", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X1, "a", 0, 0, 0, 1, -1, 0, 0));
        // last column and page: only three columns fit before the edge
        directed_rows.push_back(dir_row(SCALE_X1, 8'hFF, 1, 127, 7, 1, 3, 129, 7));
        // already past the edge: nothing comes out, no done flag either
        directed_rows.push_back(dir_row(SCALE_X1, "M", 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X2, "M", 1, 10, 3, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X2, "8", 0, 0, 0, 1, -1, 0, 0));
        // no start mark after a final character keeps going
        directed_rows.push_back(dir_row(SCALE_X2, "W", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X4, 8'h20, 1, 100, 5, 0, 24, 102, 5));
        directed_rows.push_back(dir_row(SCALE_X4, "W", 0, 0, 0, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X4, CODE_DEGREE, 1, 127, 7, 1, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_X4, 8'h7F, 1, 0, 0, 1, 24, 2, 0));
        // reserved scale code renders at normal size
        directed_rows.push_back(dir_row(SCALE_RSVD, "K", 1, 5, 2, 0, -1, 0, 0));
        directed_rows.push_back(dir_row(SCALE_RSVD, 8'h80, 0, 0, 0, 1, 6, 13, 2));
        directed_rows.push_back(dir_row(SCALE_X1, CODE_PLUS, 1, 126, 4, 1, -1, 0, 0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].scale != scale_reg) set_scale(directed_rows[i].scale);
            send_char(directed_rows[i].rq, directed_rows[i].tn, directed_rows[i].tcol,
                      directed_rows[i].tpg);
        end

        // random strings under a sequence of scale settings
        phase_scale = '{SCALE_X2, SCALE_X1, SCALE_X4, SCALE_RSVD,
                        SCALE_X4, SCALE_X2, SCALE_X1, SCALE_X4};
        phase_scale[RANDOM_PHASES-1] = 2'($urandom_range(0, 3));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_scale(phase_scale[p]);
            phase_sent = 0;
            while (phase_sent < PHASE_CHARS) begin
                if ($urandom_range(0, 99) < 80) begin
                    // well-formed string: start mark first, final mark last
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        rq.code  = pick_code();
                        rq.start = (k == 0);
                        rq.col   = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 40))
                                                               : 7'($urandom_range(41, 127));
                        rq.page  = 3'($urandom);
                        rq.fin   = (k == len - 1);
                        send_char(rq, -1, 0, 0);
                        phase_sent++;
                    end
                end else begin
                    // noise: any field combination
                    rq.code  = 8'($urandom);
                    rq.start = 1'($urandom);
                    rq.col   = 7'($urandom);
                    rq.page  = 3'($urandom);
                    rq.fin   = 1'($urandom);
                    send_char(rq, -1, 0, 0);
                    phase_sent++;
                end
            end
        end

        wait_idle();
        $display("Sent %0d characters (%0d fully clipped), checked %0d display columns",
                 chars_sent, chars_dropped, columns_checked);
        $display("Scale register written %0d times, settings used mask %b",
                 scale_writes, scales_seen);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total", err_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/scgr_pkg.sv
sv/scgr_front.sv
sv/scgr_back.sv
sv/scaled_glyph_column_renderer.sv
tb/sv/tb_top.sv
